// ----- design/smc_pkg.sv -----
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and constants of the stack machine core.
// ----------------------------------------------------------------------------
`default_nettype none
package smc_pkg;
  localparam int unsigned DataDepth   = 256;
  localparam int unsigned RetDepth    = 256;
  localparam int unsigned MemWords    = 4096;
  localparam int unsigned DAW         = $clog2(DataDepth);
  localparam int unsigned RAW         = $clog2(RetDepth);
  localparam int unsigned MAW         = $clog2(MemWords);
  localparam int unsigned DCW         = DAW + 1;
  localparam int unsigned RCW         = RAW + 1;

  typedef enum logic [3:0] {
    CMD_PUSH = 4'd0, CMD_ADD = 4'd1, CMD_SUB = 4'd2, CMD_MUL = 4'd3,
    CMD_DIV = 4'd4, CMD_MOD = 4'd5, CMD_FETCH = 4'd6, CMD_STORE = 4'd7,
    CMD_APPEND = 4'd8, CMD_PTR = 4'd9, CMD_TOR = 4'd10, CMD_FROMR = 4'd11
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DUNDER = 3'd1, ST_DOVER = 3'd2, ST_RUNDER = 3'd3, ST_ROVER = 3'd4
  } status_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       accept;    // latch the request
    logic       pop_b;     // capture b from read data
    logic       pop_a;
    logic       pop_r;
    logic       alu;       // compute the result value
    logic       div_go;
    logic       push_d;
    logic       push_r;
    logic       wr_m;
    logic       done;      // capture top and emit result
  } ctl_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;
endpackage
`default_nettype wire

// ----- design/smc_ram.sv -----
// ----------------------------------------------------------------------------
// smc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module smc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- design/smc_div.sv -----
// ----------------------------------------------------------------------------
// smc_div
// Radix-2 restoring divider on magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module smc_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quot,
  output logic [31:0]      rem
);
  logic [31:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] trial;

  assign trial = {r_r, q_r[31]} - {1'b0, d_r};

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    if (go) begin
      q_nxt = dividend; r_nxt = '0; d_nxt = divisor; cnt_nxt = 6'd32;
    end else if (cnt_r != 6'd0) begin
      if (!trial[32]) begin
        r_nxt = trial[31:0]; q_nxt = {q_r[30:0], 1'b1};
      end else begin
        r_nxt = {r_r[30:0], q_r[31]}; q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt;
  end

  assign busy = (cnt_r != 6'd0);
  assign quot = q_r;
  assign rem  = r_r;
endmodule
`default_nettype wire

// ----- design/smc_datapath.sv -----
// ----------------------------------------------------------------------------
// smc_datapath
// Stacks, word memory, pointers and the arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
module smc_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire smc_pkg::ctl_t          ctl,
  output smc_pkg::sts_t               sts,
  input  wire logic [3:0]             in_command,
  input  wire logic [31:0]            in_literal,
  input  wire logic [11:0]            cfg_alloc_start,
  output logic [31:0]                 out_top_value,
  output logic [8:0]                  out_data_depth,
  output logic [8:0]                  out_return_depth,
  output logic [2:0]                  out_status
);
  localparam logic [smc_pkg::DCW-1:0] DFULL = smc_pkg::DCW'(smc_pkg::DataDepth);
  localparam logic [smc_pkg::RCW-1:0] RFULL = smc_pkg::RCW'(smc_pkg::RetDepth);

  logic [3:0]  cmd_r;
  logic [31:0] lit_r, a_r, b_r, v_r, v_nxt, top_r;
  logic [smc_pkg::DCW-1:0] dcnt_r, dcnt_nxt;
  logic [smc_pkg::RCW-1:0] rcnt_r, rcnt_nxt;
  logic [smc_pkg::MAW-1:0] ap_r, ap_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        an_r, bn_r;

  logic d_we, r_we, m_we;
  logic [smc_pkg::DAW-1:0] d_addr;
  logic [smc_pkg::RAW-1:0] r_addr;
  logic [smc_pkg::MAW-1:0] m_addr;
  logic [31:0] d_wd, r_wd, m_wd, d_rd, r_rd, m_rd;
  logic [31:0] quot, rem, ua, ub;
  logic        div_busy;

  // Memory has all-zero reset: clear sweep flag.
  logic [smc_pkg::MAW:0] clr_r;
  logic clearing;
  assign clearing = !clr_r[smc_pkg::MAW];

  smc_ram #(.Width(32), .Depth(smc_pkg::DataDepth)) u_dstk (
    .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wd), .rdata(d_rd));
  smc_ram #(.Width(32), .Depth(smc_pkg::RetDepth)) u_rstk (
    .clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wd), .rdata(r_rd));
  smc_ram #(.Width(32), .Depth(smc_pkg::MemWords)) u_wmem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));

  assign ua = an_r ? (32'd0 - a_r) : a_r;
  assign ub = bn_r ? (32'd0 - b_r) : b_r;

  smc_div u_div (.clk(clk), .rst_n(rst_n), .go(ctl.div_go), .dividend(ua),
    .divisor(ub), .busy(div_busy), .quot(quot), .rem(rem));
  assign sts.div_busy = div_busy;

  function automatic logic [2:0] note(input logic [2:0] cur, input logic [2:0] code);
    note = (cur == smc_pkg::ST_OK) ? code : cur;
  endfunction

  // Stack addressing: pop reads count-1, and while b is popped read count-2 so
  // that a arrives next cycle; push writes count, or top when full.
  always_comb begin
    d_we = 1'b0; d_wd = v_r;
    d_addr = smc_pkg::DAW'(dcnt_r - smc_pkg::DCW'(1));
    if (ctl.pop_b) d_addr = smc_pkg::DAW'(dcnt_r - smc_pkg::DCW'(2));
    if (ctl.push_d) begin
      d_we = 1'b1;
      if (dcnt_r < DFULL) d_addr = dcnt_r[smc_pkg::DAW-1:0];
    end
    r_we = ctl.push_r; r_wd = v_r;
    r_addr = smc_pkg::RAW'(rcnt_r - smc_pkg::RCW'(1));
    if (ctl.push_r && rcnt_r < RFULL) r_addr = rcnt_r[smc_pkg::RAW-1:0];
    m_we = clearing || ctl.wr_m;
    m_wd = clearing ? 32'd0 : v_r;
    if (clearing) m_addr = clr_r[smc_pkg::MAW-1:0];
    else if (cmd_r == smc_pkg::CMD_APPEND) m_addr = ap_r + smc_pkg::MAW'(1);
    else m_addr = b_r[smc_pkg::MAW-1:0];
  end

  always_comb begin
    dcnt_nxt = dcnt_r; rcnt_nxt = rcnt_r; st_nxt = st_r; ap_nxt = ap_r; v_nxt = v_r;
    if (ctl.accept) st_nxt = smc_pkg::ST_OK;
    if ((ctl.pop_b || ctl.pop_a) && dcnt_r == '0) st_nxt = note(st_r, smc_pkg::ST_DUNDER);
    if ((ctl.pop_b || ctl.pop_a) && dcnt_r != '0) dcnt_nxt = dcnt_r - smc_pkg::DCW'(1);
    if (ctl.pop_r) begin
      if (rcnt_r == '0) st_nxt = note(st_r, smc_pkg::ST_RUNDER);
      else rcnt_nxt = rcnt_r - smc_pkg::RCW'(1);
    end
    if (ctl.push_d) begin
      if (dcnt_r >= DFULL) st_nxt = note(st_r, smc_pkg::ST_DOVER);
      else dcnt_nxt = dcnt_r + smc_pkg::DCW'(1);
    end
    if (ctl.push_r) begin
      if (rcnt_r >= RFULL) st_nxt = note(st_r, smc_pkg::ST_ROVER);
      else rcnt_nxt = rcnt_r + smc_pkg::RCW'(1);
    end
    if (ctl.alu) begin
      case (cmd_r)
        smc_pkg::CMD_PUSH:   v_nxt = lit_r;
        smc_pkg::CMD_ADD:    v_nxt = a_r + b_r;
        smc_pkg::CMD_SUB:    v_nxt = a_r - b_r;
        smc_pkg::CMD_MUL:    v_nxt = a_r * b_r;
        smc_pkg::CMD_DIV:    v_nxt = (b_r == '0) ? 32'd0 :
                                     ((an_r != bn_r) ? 32'd0 - quot : quot);
        smc_pkg::CMD_MOD:    v_nxt = (b_r == '0) ? 32'd0 : (an_r ? 32'd0 - rem : rem);
        smc_pkg::CMD_FETCH:  v_nxt = m_rd;
        smc_pkg::CMD_STORE:  v_nxt = a_r;
        smc_pkg::CMD_APPEND: v_nxt = b_r;
        smc_pkg::CMD_PTR:    v_nxt = 32'(ap_r);
        smc_pkg::CMD_TOR:    v_nxt = b_r;
        smc_pkg::CMD_FROMR:  v_nxt = b_r;
        default:             v_nxt = v_r;
      endcase
    end
    if (ctl.wr_m && cmd_r == smc_pkg::CMD_APPEND) ap_nxt = ap_r + smc_pkg::MAW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0; rcnt_r <= '0; st_r <= smc_pkg::ST_OK;
      ap_r <= cfg_alloc_start[smc_pkg::MAW-1:0]; clr_r <= '0;
    end else begin
      dcnt_r <= dcnt_nxt; rcnt_r <= rcnt_nxt; st_r <= st_nxt; ap_r <= ap_nxt;
      if (clearing) clr_r <= clr_r + (smc_pkg::MAW+1)'(1);
    end
    v_r <= v_nxt;
    if (ctl.accept) begin cmd_r <= in_command; lit_r <= in_literal; end
    if (ctl.pop_b) begin
      b_r <= (dcnt_r == '0) ? 32'd0 : d_rd; bn_r <= (dcnt_r != '0) && d_rd[31];
    end
    if (ctl.pop_r) begin
      b_r <= (rcnt_r == '0) ? 32'd0 : r_rd;
    end
    if (ctl.pop_a) begin
      a_r <= (dcnt_r == '0) ? 32'd0 : d_rd; an_r <= (dcnt_r != '0) && d_rd[31];
    end
    if (ctl.done) top_r <= (dcnt_r == '0) ? 32'd0 : d_rd;
  end

  assign out_top_value    = top_r;
  assign out_data_depth   = 9'(dcnt_r);
  assign out_return_depth = 9'(rcnt_r);
  assign out_status       = st_r;
endmodule
`default_nettype wire

// ----- design/smc_ctrl.sv -----
// ----------------------------------------------------------------------------
// smc_ctrl
// Command sequencer for the stack machine core.
// ----------------------------------------------------------------------------
`default_nettype none
module smc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          ready,
  input  wire logic [3:0]    in_command,
  input  wire smc_pkg::sts_t sts,
  output smc_pkg::ctl_t      ctl,
  output logic               busy,
  output logic               out_valid
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001, S_RDB = 11'b00000000010, S_POPB = 11'b00000000100,
    S_POPA  = 11'b00000001000, S_DIV = 11'b00000010000, S_MRD = 11'b00000100000,
    S_MCAP  = 11'b00001000000, S_ALU = 11'b00010000000, S_WR  = 11'b00100000000,
    S_TOP   = 11'b01000000000, S_DONE = 11'b10000000000
  } state_t;

  state_t st_r, st_nxt;
  logic [3:0] cmd_r;
  logic done_r;

  always_comb begin
    ctl = '0;
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (start && ready) begin ctl.accept = 1'b1; st_nxt = S_RDB; end
      end
      S_RDB: begin
        // address is count-1 on both stacks: read data arrives next cycle
        case (cmd_r)
          smc_pkg::CMD_PUSH, smc_pkg::CMD_PTR: st_nxt = S_ALU;
          default: if (cmd_r > smc_pkg::CMD_FROMR) st_nxt = S_TOP; else st_nxt = S_POPB;
        endcase
      end
      S_POPB: begin
        if (cmd_r == smc_pkg::CMD_FROMR) ctl.pop_r = 1'b1; else ctl.pop_b = 1'b1;
        if (cmd_r inside {smc_pkg::CMD_ADD, smc_pkg::CMD_SUB, smc_pkg::CMD_MUL,
                          smc_pkg::CMD_DIV, smc_pkg::CMD_MOD, smc_pkg::CMD_STORE})
          st_nxt = S_POPA;
        else if (cmd_r == smc_pkg::CMD_FETCH) st_nxt = S_MRD;
        else if (cmd_r == smc_pkg::CMD_APPEND) st_nxt = S_ALU;
        else st_nxt = S_ALU;
      end
      S_POPA: begin
        // read of new top was issued while popping b
        ctl.pop_a = 1'b1;
        if (cmd_r == smc_pkg::CMD_DIV || cmd_r == smc_pkg::CMD_MOD) st_nxt = S_DIV;
        else st_nxt = S_ALU;
      end
      S_DIV: begin
        ctl.div_go = 1'b1; st_nxt = S_MCAP;
      end
      S_MCAP: begin
        if (cmd_r == smc_pkg::CMD_FETCH || !sts.div_busy) st_nxt = S_ALU;
      end
      S_MRD: st_nxt = S_MCAP;
      S_ALU: begin
        ctl.alu = 1'b1; st_nxt = S_WR;
      end
      S_WR: begin
        case (cmd_r)
          smc_pkg::CMD_STORE: begin ctl.wr_m = 1'b1; st_nxt = S_TOP; end
          smc_pkg::CMD_APPEND: begin ctl.wr_m = 1'b1; st_nxt = S_MRD; end
          smc_pkg::CMD_TOR: begin ctl.push_r = 1'b1; st_nxt = S_TOP; end
          default: begin ctl.push_d = 1'b1; st_nxt = S_TOP; end
        endcase
      end
      S_TOP: st_nxt = S_DONE;
      S_DONE: begin ctl.done = 1'b1; st_nxt = S_IDLE; end
      default: st_nxt = S_IDLE;
    endcase
    // append: the write address is the old pointer + 1; the pointer advances with the write
    if (st_r == S_MRD && cmd_r == smc_pkg::CMD_APPEND) st_nxt = S_TOP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; done_r <= 1'b0;
    end else begin
      st_r <= st_nxt; done_r <= ctl.done;
    end
    if (ctl.accept) cmd_r <= in_command;
  end

  assign busy = (st_r != S_IDLE) || !ready;
  assign out_valid = done_r;

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("state not one-hot");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept |-> st_r == S_IDLE) else $error("accept outside idle");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
endmodule
`default_nettype wire

// ----- design/stack_machine_core.sv -----
// ----------------------------------------------------------------------------
// stack_machine_core
// One stack-machine command per request; one result per request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The result appears on
// the out_ ports for one cycle, flagged by out_valid; the receiver cannot hold
// it off. Busy stays high until a command is through, so a new request waits.
// Commands step through the registered stack and memory reads; div and mod
// also wait for the divider, which yields one quotient bit a cycle. After reset
// the word memory is swept to zero, one word a cycle, and busy stays high until
// that ends. cfg_alloc_start is loaded into the allocation pointer at reset.
`default_nettype none
module stack_machine_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  in_command,
  input  wire logic [31:0] in_literal,
  output logic             out_valid,
  output logic [31:0]      out_top_value,
  output logic [8:0]       out_data_depth,
  output logic [8:0]       out_return_depth,
  output logic [2:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata
);
  smc_pkg::ctl_t ctl;
  smc_pkg::sts_t sts;
  logic [11:0] alloc_start_r;
  logic [12:0] sweep_r;
  logic        ready;

  // hold the register; reset loads its default
  always_ff @(posedge clk) begin
    if (!rst_n) alloc_start_r <= 12'd2;
    else if (cfg_we) alloc_start_r <= cfg_wdata;
  end

  // track the memory clearing sweep in step with the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) sweep_r <= '0;
    else if (!sweep_r[12]) sweep_r <= sweep_r + 13'd1;
  end
  assign ready = sweep_r[12];

  smc_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .ready(ready),
    .in_command(in_command), .sts(sts), .ctl(ctl), .busy(busy), .out_valid(out_valid));

  smc_datapath u_dp (.clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_command(in_command), .in_literal(in_literal), .cfg_alloc_start(alloc_start_r),
    .out_top_value(out_top_value), .out_data_depth(out_data_depth),
    .out_return_depth(out_return_depth), .out_status(out_status));
endmodule
`default_nettype wire
